// File: rtl/gaps_pkg.sv
// ----------------------------------------------------------------------------
// gaps_pkg
// Shared types and constants of the grid A* path search block.
// ----------------------------------------------------------------------------
package gaps_pkg;

   // grid geometry (GRID_SIDE is a power of two)
   localparam int GRID_SIDE   = 32;
   localparam int WEIGHT_BITS = 8;
   localparam int CELLS       = GRID_SIDE * GRID_SIDE;
   localparam int XY_BITS     = $clog2(GRID_SIDE);
   localparam int IDX_BITS    = $clog2(CELLS);
   localparam int CNT_BITS    = IDX_BITS + 1;

   // fixed point costs, units of 1/256
   localparam int COST_BITS = 20;
   localparam int F_BITS    = COST_BITS + 1;
   localparam logic [COST_BITS-1:0] COST_MAX  = '1;
   localparam int                   UNIT_COST = 256;

   // item opcodes
   typedef enum logic [1:0] {
      OP_LOAD   = 2'd0,
      OP_SEARCH = 2'd1,
      OP_READ   = 2'd2
   } op_type;

   // configuration register indexes
   localparam int CSR_IDX_BITS  = 3;
   localparam int CSR_DATA_BITS = 5;
   localparam logic [CSR_IDX_BITS-1:0] CSR_START_X  = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_START_Y  = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_GOAL_X   = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_GOAL_Y   = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_WEIGHTED = 3'd4;
   localparam logic [4:0] GOAL_RESET = 5'd31;

   // channel payloads
   typedef struct packed {
      logic [1:0]  op;
      logic [4:0]  cell_x;
      logic [4:0]  cell_y;
      logic        blocked;
      logic [7:0]  cell_weight;
      logic [9:0]  path_index;
   } req_type;

   typedef struct packed {
      logic        found;
      logic [10:0] path_length;
      logic [19:0] path_cost;
      logic [4:0]  path_x;
      logic [4:0]  path_y;
   } rsp_type;

   // one entry of the search memory
   typedef struct packed {
      logic                 open;
      logic                 closed;
      logic [COST_BITS-1:0] cost;
      logic [IDX_BITS-1:0]  parent;
   } srch_type;

   // map memory entry
   typedef struct packed {
      logic                   blocked;
      logic [WEIGHT_BITS-1:0] weight;
   } map_type;

   // commands from channel control to the engine
   typedef struct packed {
      logic                   start;
      logic                   weighted;
      logic [4:0]             start_x;
      logic [4:0]             start_y;
      logic [4:0]             goal_x;
      logic [4:0]             goal_y;
      logic                   map_we;
      logic [IDX_BITS-1:0]    map_addr;
      logic                   map_blocked;
      logic [WEIGHT_BITS-1:0] map_weight;
      logic [IDX_BITS-1:0]    path_raddr;
   } eng_cmd_type;

   // engine status
   typedef struct packed {
      logic                 busy;
      logic                 done;
      logic                 found;
      logic [CNT_BITS-1:0]  count;
      logic [COST_BITS-1:0] cost;
   } eng_stat_type;

endpackage

// File: rtl/gaps_engine.sv
// ----------------------------------------------------------------------------
// gaps_engine
// Holds the map, search and path memories and runs the A* sequencer:
// map clear after reset, flag clear, min-f scan, neighbour relaxation and path walk-back.
// ----------------------------------------------------------------------------
module gaps_engine (
   input  logic                          clock,
   input  logic                          reset,
   input  gaps_pkg::eng_cmd_type         cmd,
   output gaps_pkg::eng_stat_type        stat,
   output logic [gaps_pkg::IDX_BITS-1:0] path_data
);

   localparam int IDX = gaps_pkg::IDX_BITS;
   localparam int XY  = gaps_pkg::XY_BITS;
   localparam int CB  = gaps_pkg::CNT_BITS;
   localparam int CS  = gaps_pkg::COST_BITS;
   localparam int FB  = gaps_pkg::F_BITS;
   localparam logic [CB-1:0]  LAST_CELL = CB'(gaps_pkg::CELLS - 1);
   localparam logic [CB-1:0]  ALL_CELLS = CB'(gaps_pkg::CELLS);
   localparam logic [XY-1:0]  EDGE_HI   = XY'(gaps_pkg::GRID_SIDE - 1);

   typedef enum logic [3:0] {
      S_MCLR, S_IDLE, S_CLR, S_INIT, S_SCAN, S_SCAN_END, S_PICK,
      S_NB_RD, S_NB_WR, S_CNT, S_CNT_W, S_PW, S_PW_W
   } state_type;

   // memories
   gaps_pkg::srch_type srch_mem [gaps_pkg::CELLS];
   gaps_pkg::map_type  map_mem  [gaps_pkg::CELLS];
   logic [IDX-1:0]     path_mem [gaps_pkg::CELLS];

   gaps_pkg::srch_type sm_rd_ff, sm_wdata;
   gaps_pkg::map_type  mp_rd_ff, mp_wdata;
   logic [IDX-1:0]     ps_rd_ff, ps_wdata, ps_waddr;
   logic [IDX-1:0]     sm_raddr, sm_waddr, mp_waddr, mp_raddr;
   logic               sm_we, mp_we, ps_we;

   state_type         state_ff, state_in;
   logic [CB-1:0]     scan_ff, n_ff, k_ff;
   logic              rdv_ff;
   logic [IDX-1:0]    rdaddr_ff;
   logic              any_ff;
   logic [IDX-1:0]    best_ff, bestp_ff;
   logic [FB-1:0]     bestf_ff;
   logic [CS-1:0]     bestg_ff;
   logic [1:0]        dir_ff;
   logic [IDX-1:0]    nb_ff, c_ff, s_ff, g_ff;
   logic              wm_ff, inrange_ff;
   logic [XY-1:0]     gx_ff, gy_ff;
   logic              found_ff, done_ff, done_in;
   logic [CB-1:0]     count_ff;
   logic [CS-1:0]     cost_ff;

   logic              scan_last, nb_ok, relax, path_end;
   logic [IDX-1:0]    nb_idx;
   logic [XY-1:0]     cx, cy;
   logic [CS:0]       t_sum;
   logic [CS-1:0]     t_cost;
   logic [FB-1:0]     f_val;

   // Manhattan heuristic to the latched goal
   function automatic logic [FB-1:0] heur(input logic [IDX-1:0] idx,
                                          input logic [XY-1:0] gx,
                                          input logic [XY-1:0] gy);
      logic [XY-1:0] x, y, dx, dy;
      logic [XY:0]   s;
      x  = idx[XY-1:0];
      y  = idx[IDX-1:XY];
      dx = (x > gx) ? x - gx : gx - x;
      dy = (y > gy) ? y - gy : gy - y;
      s  = {1'b0, dx} + {1'b0, dy};
      return FB'({s, 8'd0});
   endfunction

   // memory ports
   always_ff @(posedge clock) begin
      if (sm_we) begin
         srch_mem[sm_waddr] <= sm_wdata;
      end
      sm_rd_ff <= srch_mem[sm_raddr];
      if (mp_we) begin
         map_mem[mp_waddr] <= mp_wdata;
      end
      mp_rd_ff <= map_mem[mp_raddr];
      if (ps_we) begin
         path_mem[ps_waddr] <= ps_wdata;
      end
      ps_rd_ff <= path_mem[cmd.path_raddr];
   end

   // neighbour of the expanded cell in the current direction
   assign cx = best_ff[XY-1:0];
   assign cy = best_ff[IDX-1:XY];
   always_comb begin
      nb_ok  = 1'b0;
      nb_idx = best_ff;
      case (dir_ff)
         2'd0: begin
            nb_ok  = (cy != '0);
            nb_idx = {cy - 1'b1, cx};
         end
         2'd1: begin
            nb_ok  = (cy != EDGE_HI);
            nb_idx = {cy + 1'b1, cx};
         end
         2'd2: begin
            nb_ok  = (cx != '0);
            nb_idx = {cy, cx - 1'b1};
         end
         default: begin
            nb_ok  = (cx != EDGE_HI);
            nb_idx = {cy, cx + 1'b1};
         end
      endcase
   end

   // tentative cost, saturating
   assign t_sum  = {1'b0, bestg_ff} + (CS+1)'(gaps_pkg::UNIT_COST)
                 + (wm_ff ? (CS+1)'(mp_rd_ff.weight) : '0);
   assign t_cost = t_sum[CS] ? gaps_pkg::COST_MAX : t_sum[CS-1:0];
   assign relax  = !mp_rd_ff.blocked && !sm_rd_ff.closed &&
                   (!sm_rd_ff.open || (t_cost < sm_rd_ff.cost));
   assign scan_last = (scan_ff == LAST_CELL);
   assign path_end  = (c_ff == s_ff) || (n_ff >= ALL_CELLS);
   assign f_val     = {1'b0, sm_rd_ff.cost} + heur(rdaddr_ff, gx_ff, gy_ff);

   // sequencer control and memory addressing
   always_comb begin
      state_in = state_ff;
      done_in  = 1'b0;
      sm_we    = 1'b0;
      sm_waddr = nb_ff;
      sm_wdata = '0;
      sm_raddr = scan_ff[IDX-1:0];
      mp_we    = 1'b0;
      mp_waddr = cmd.map_addr;
      mp_wdata = {cmd.map_blocked, cmd.map_weight};
      mp_raddr = nb_idx;
      ps_we    = 1'b0;
      ps_waddr = IDX'(n_ff - k_ff - 1'b1);
      ps_wdata = c_ff;
      case (state_ff)
         S_MCLR: begin
            mp_we    = 1'b1;
            mp_waddr = scan_ff[IDX-1:0];
            mp_wdata = '0;
            if (scan_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            mp_we = cmd.map_we;
            if (cmd.start) state_in = S_CLR;
         end
         S_CLR: begin
            sm_we    = 1'b1;
            sm_waddr = scan_ff[IDX-1:0];
            if (scan_last) state_in = S_INIT;
         end
         S_INIT: begin
            if (!inrange_ff) begin
               state_in = S_IDLE;
               done_in  = 1'b1;
            end else begin
               sm_we    = 1'b1;
               sm_waddr = s_ff;
               sm_wdata = '{open: 1'b1, closed: 1'b0, cost: '0, parent: s_ff};
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (scan_last) state_in = S_SCAN_END;
         end
         S_SCAN_END: begin
            state_in = S_PICK;
         end
         S_PICK: begin
            if (!any_ff) begin
               state_in = S_IDLE;
               done_in  = 1'b1;
            end else if (best_ff == g_ff) begin
               state_in = S_CNT;
            end else begin
               sm_we    = 1'b1;
               sm_waddr = best_ff;
               sm_wdata = '{open: 1'b0, closed: 1'b1, cost: bestg_ff, parent: bestp_ff};
               state_in = S_NB_RD;
            end
         end
         S_NB_RD: begin
            sm_raddr = nb_idx;
            if (nb_ok) state_in = S_NB_WR;
            else if (dir_ff == 2'd3) state_in = S_SCAN;
         end
         S_NB_WR: begin
            sm_we    = relax;
            sm_wdata = '{open: 1'b1, closed: 1'b0, cost: t_cost, parent: best_ff};
            state_in = (dir_ff == 2'd3) ? S_SCAN : S_NB_RD;
         end
         S_CNT: begin
            sm_raddr = c_ff;
            state_in = path_end ? S_PW : S_CNT_W;
         end
         S_CNT_W: begin
            state_in = S_CNT;
         end
         S_PW: begin
            ps_we    = 1'b1;
            sm_raddr = c_ff;
            if (k_ff + 1'b1 == n_ff) begin
               state_in = S_IDLE;
               done_in  = 1'b1;
            end else begin
               state_in = S_PW_W;
            end
         end
         S_PW_W: begin
            state_in = S_PW;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // sequencer state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_MCLR;
         scan_ff  <= '0;
         rdv_ff   <= 1'b0;
         any_ff   <= 1'b0;
         done_ff  <= 1'b0;
         found_ff <= 1'b0;
         count_ff <= '0;
         cost_ff  <= '0;
         dir_ff   <= '0;
      end else begin
         state_ff  <= state_in;
         done_ff   <= done_in;
         rdv_ff    <= (state_ff == S_SCAN);
         rdaddr_ff <= scan_ff[IDX-1:0];
         case (state_ff)
            S_MCLR, S_CLR, S_SCAN: begin
               scan_ff <= scan_last ? '0 : scan_ff + 1'b1;
            end
            S_IDLE: begin
               if (cmd.start) begin
                  s_ff       <= {cmd.start_y[XY-1:0], cmd.start_x[XY-1:0]};
                  g_ff       <= {cmd.goal_y[XY-1:0], cmd.goal_x[XY-1:0]};
                  gx_ff      <= cmd.goal_x[XY-1:0];
                  gy_ff      <= cmd.goal_y[XY-1:0];
                  wm_ff      <= cmd.weighted;
                  inrange_ff <= (int'(cmd.start_x) < gaps_pkg::GRID_SIDE) &&
                                (int'(cmd.start_y) < gaps_pkg::GRID_SIDE) &&
                                (int'(cmd.goal_x) < gaps_pkg::GRID_SIDE) &&
                                (int'(cmd.goal_y) < gaps_pkg::GRID_SIDE);
                  scan_ff    <= '0;
                  found_ff   <= 1'b0;
                  count_ff   <= '0;
                  cost_ff    <= '0;
               end
            end
            S_INIT: begin
               any_ff  <= 1'b0;
               scan_ff <= '0;
            end
            S_PICK: begin
               dir_ff <= '0;
               c_ff   <= g_ff;
               n_ff   <= CB'(1);
            end
            S_NB_RD: begin
               nb_ff <= nb_idx;
               if (!nb_ok) begin
                  dir_ff <= dir_ff + 1'b1;
                  if (dir_ff == 2'd3) any_ff <= 1'b0;
               end
            end
            S_NB_WR: begin
               dir_ff <= dir_ff + 1'b1;
               if (dir_ff == 2'd3) any_ff <= 1'b0;
            end
            S_CNT: begin
               if (path_end) begin
                  c_ff <= g_ff;
                  k_ff <= '0;
               end
            end
            S_CNT_W: begin
               c_ff <= sm_rd_ff.parent;
               n_ff <= n_ff + 1'b1;
            end
            S_PW: begin
               k_ff <= k_ff + 1'b1;
               if (k_ff + 1'b1 == n_ff) begin
                  found_ff <= 1'b1;
                  count_ff <= n_ff;
                  cost_ff  <= bestg_ff;
               end
            end
            S_PW_W: begin
               c_ff <= sm_rd_ff.parent;
            end
            default: begin
            end
         endcase
         // min-f tracking on scan read data, ties keep the lower index
         if (rdv_ff && sm_rd_ff.open && (!any_ff || (f_val < bestf_ff))) begin
            any_ff   <= 1'b1;
            best_ff  <= rdaddr_ff;
            bestf_ff <= f_val;
            bestg_ff <= sm_rd_ff.cost;
            bestp_ff <= sm_rd_ff.parent;
         end
      end
   end

   assign stat.busy  = (state_ff != S_IDLE);
   assign stat.done  = done_ff;
   assign stat.found = found_ff;
   assign stat.count = count_ff;
   assign stat.cost  = cost_ff;
   assign path_data  = ps_rd_ff;

endmodule

// File: rtl/grid_astar_path_search.sv
// A load's result is registered in the cycle after acceptance; a path read
// passes the path memory read register first. A search clears the search
// flags, then per expanded cell does a min-f scan and neighbour updates, then
// count and store walks of the path. Loads: one per cycle when not stalled.
// Reset: synchronous; a map clearing pass follows, input stalled.
// ----------------------------------------------------------------------------
// grid_astar_path_search
// A* search on a 4-connected grid with cell loads and path read-back.
// ----------------------------------------------------------------------------
module grid_astar_path_search (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  gaps_pkg::req_type                     req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output gaps_pkg::rsp_type                     rsp_data,
   input  logic                                  csr_we,
   input  logic [gaps_pkg::CSR_IDX_BITS-1:0]     csr_index,
   input  logic [gaps_pkg::CSR_DATA_BITS-1:0]    csr_wdata
);

   localparam int XY  = gaps_pkg::XY_BITS;
   localparam int IDX = gaps_pkg::IDX_BITS;

   logic [4:0] start_x_ff, start_y_ff, goal_x_ff, goal_y_ff;
   logic       weighted_ff;

   gaps_pkg::eng_cmd_type  cmd;
   gaps_pkg::eng_stat_type stat;
   logic [IDX-1:0]         path_data;

   gaps_pkg::rsp_type rsp_ff, rsp_in;
   logic              rsp_valid_ff, load_rsp;
   logic              pend_ff, srch_ff, pok_ff;
   logic              acc, in_grid;
   gaps_pkg::rsp_type status;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         start_x_ff  <= '0;
         start_y_ff  <= '0;
         goal_x_ff   <= gaps_pkg::GOAL_RESET;
         goal_y_ff   <= gaps_pkg::GOAL_RESET;
         weighted_ff <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            gaps_pkg::CSR_START_X:  start_x_ff  <= csr_wdata;
            gaps_pkg::CSR_START_Y:  start_y_ff  <= csr_wdata;
            gaps_pkg::CSR_GOAL_X:   goal_x_ff   <= csr_wdata;
            gaps_pkg::CSR_GOAL_Y:   goal_y_ff   <= csr_wdata;
            gaps_pkg::CSR_WEIGHTED: weighted_ff <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   // input handshake
   assign req_stall = stat.busy | pend_ff | srch_ff | (rsp_valid_ff & rsp_stall);
   assign acc       = req_valid & ~req_stall;
   assign in_grid   = (int'(req_data.cell_x) < gaps_pkg::GRID_SIDE) &&
                      (int'(req_data.cell_y) < gaps_pkg::GRID_SIDE);

   // engine commands
   always_comb begin
      cmd.start       = acc && (req_data.op == gaps_pkg::OP_SEARCH);
      cmd.weighted    = weighted_ff;
      cmd.start_x     = start_x_ff;
      cmd.start_y     = start_y_ff;
      cmd.goal_x      = goal_x_ff;
      cmd.goal_y      = goal_y_ff;
      cmd.map_we      = acc && (req_data.op == gaps_pkg::OP_LOAD) && in_grid;
      cmd.map_addr    = {req_data.cell_y[XY-1:0], req_data.cell_x[XY-1:0]};
      cmd.map_blocked = req_data.blocked;
      cmd.map_weight  = req_data.cell_weight[gaps_pkg::WEIGHT_BITS-1:0];
      cmd.path_raddr  = req_data.path_index[IDX-1:0];
   end

   gaps_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .stat      (stat),
      .path_data (path_data)
   );

   // status part of every result item
   always_comb begin
      status.found       = stat.found;
      status.path_length = 11'(stat.count);
      status.path_cost   = stat.cost;
      status.path_x      = '0;
      status.path_y      = '0;
   end

   // result item selection
   always_comb begin
      load_rsp = 1'b0;
      rsp_in   = status;
      if (pend_ff) begin
         load_rsp = 1'b1;
         if (pok_ff) begin
            rsp_in.path_x = 5'(path_data[XY-1:0]);
            rsp_in.path_y = 5'(path_data[IDX-1:XY]);
         end
      end else if (srch_ff) begin
         load_rsp = stat.done;
      end else if (acc) begin
         case (req_data.op)
            gaps_pkg::OP_SEARCH, gaps_pkg::OP_READ: load_rsp = 1'b0;
            default: load_rsp = 1'b1;
         endcase
      end
   end

   // output register and item tracking
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
         srch_ff      <= 1'b0;
      end else begin
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         pend_ff <= acc && (req_data.op == gaps_pkg::OP_READ);
         if (cmd.start) begin
            srch_ff <= 1'b1;
         end else if (stat.done) begin
            srch_ff <= 1'b0;
         end
      end
      if (load_rsp) begin
         rsp_ff <= rsp_in;
      end
      pok_ff <= ({1'b0, req_data.path_index} < 11'(stat.count));
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
